>>> hdl/bba_pkg.sv
// Package: shared types, constants and codes for the bitmap block allocator.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF  = 1024;
    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int WORD_BITS_DEF   = 32;

    localparam int ACT_W  = 2;
    localparam int ADDR_W = 22;
    localparam int LEN_W  = 11;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

    localparam logic [0:0] REG_MANAGED = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_LATCH,
        S_SCAN,
        S_MARK,
        S_CLEAR,
        S_TEST,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic latch;
        logic scan_step;
        logic mark_step;
        logic clear_step;
        logic test_step;
        logic finish;
        logic push;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             req_bad;
        logic             scan_found;
        logic             scan_end;
        logic             run_end;
        logic             word_last;
        logic             marking;
        logic             out_busy;
    } t_stat;

endpackage

>>> hdl/bitmap_block_allocator.sv
// Top level: bitmap first-fit block allocator with APB limit register.
//
//  channel | signals                                      | dir
//  in      | i_in_valid/o_in_ready, action,address,length | in
//  out     | o_out_valid/i_out_ready, status..free_count  | out
//  cfg     | psel penable pwrite paddr pwdata prdata      | in/out
//
// A bad request goes straight to the result; a test fetches and latches one word, then tests the bit.
// Free: each bitmap word touched is fetched and latched, then its blocks are cleared.
// Allocate: each word read is fetched, latched and scanned block by block; on a fit the run is marked.
// Reset: unwritten words read as all used, free count zero; no clearing pass.
// One request at a time; a held result stalls only the next request's result.
module bitmap_block_allocator import bba_pkg::*; #(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [LEN_W-1:0]  i_run_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [ADDR_W-1:0] o_run_address,
    output logic              o_block_used,
    output logic [CNT_W-1:0]  o_free_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cmd  cmd;
    t_stat stat;
    logic [LEN_W-1:0] r_managed;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MANAGED) ? {21'd0, r_managed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_managed <= LEN_W'(1024);
        end else if (psel && penable && pwrite && paddr[2] == REG_MANAGED) begin
            r_managed <= pwdata[LEN_W-1:0];
        end
    end

    bba_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    bba_dp #(
        .NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES), .WORD_BITS(WORD_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat), .i_managed(r_managed),
        .i_action(i_action), .i_address(i_address), .i_run_length(i_run_length),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_run_address(o_run_address),
        .o_block_used(o_block_used), .o_free_count(o_free_count)
    );

    a_used_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_block_used |-> o_status == ST_OK)
        else $error("block_used set on a failed request");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_free_count))
        else $error("result changed while stalled");
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_run_address == '0)
        else $error("nonzero address on failure");

endmodule

>>> hdl/bba_ctrl.sv
// Controller: sequences fetch, scan, mark, clear and test steps of one request.
module bba_ctrl import bba_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.req_bad) n_state = S_DONE;
                else n_state = S_FETCH;
            end
            S_FETCH: n_state = S_LATCH;
            S_LATCH: begin
                case (i_stat.action)
                    ACT_ALLOC: n_state = i_stat.marking ? S_MARK : S_SCAN;
                    ACT_FREE:  n_state = S_CLEAR;
                    default:   n_state = S_TEST;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_found) n_state = S_FETCH;
                else if (i_stat.scan_end) n_state = S_DONE;
                else if (i_stat.word_last) n_state = S_FETCH;
            end
            S_MARK: begin
                if (i_stat.run_end) n_state = S_DONE;
                else if (i_stat.word_last) n_state = S_FETCH;
            end
            S_CLEAR: begin
                if (i_stat.run_end) n_state = S_DONE;
                else if (i_stat.word_last) n_state = S_FETCH;
            end
            S_TEST:  n_state = S_DONE;
            S_DONE: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: o_cmd.finish = i_stat.req_bad;
            S_FETCH: o_cmd.fetch  = 1'b1;
            S_LATCH: o_cmd.latch  = 1'b1;
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.finish    = i_stat.scan_end;
            end
            S_MARK:  o_cmd.mark_step  = 1'b1;
            S_CLEAR: o_cmd.clear_step = 1'b1;
            S_TEST:  o_cmd.test_step  = 1'b1;
            S_DONE:  o_cmd.push       = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

>>> hdl/bba_dp.sv
// Datapath: bitmap memory, run scan counters, free count and result registers.
module bba_dp import bba_pkg::*; #(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [LEN_W-1:0]  i_managed,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [LEN_W-1:0]  i_run_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [ADDR_W-1:0] o_run_address,
    output logic              o_block_used,
    output logic [CNT_W-1:0]  o_free_count
);

    localparam int BSH   = $clog2(BLOCK_BYTES);
    localparam int BNW   = $clog2(NUM_BLOCKS + 1) + 1;
    localparam int BW    = (ADDR_W - BSH + 1 > BNW) ? ADDR_W - BSH + 1 : BNW;
    localparam int BIW   = $clog2(WORD_BITS);
    localparam int WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW    = BW + LEN_W + 1;

    // bitmap words; a word never written reads as all used
    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_wok;
    logic [WORD_BITS-1:0] r_rd, r_word, n_word;
    logic                 r_rd_ok;

    logic [ACT_W-1:0]  r_act;
    logic [BW-1:0]     r_blk, r_pos, r_cnt, r_end, r_limit;
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_free;
    logic [ST_W-1:0]   r_status;
    logic [ADDR_W-1:0] r_raddr;
    logic              r_used;
    logic              r_found;
    logic              r_ovalid;
    logic [ST_W-1:0]   r_ostatus;
    logic [ADDR_W-1:0] r_oraddr;
    logic              r_oused;
    logic [CNT_W-1:0]  r_ofree;

    logic [BW-1:0]  n_limit, n_blk;
    logic [LW-1:0]  blk_ext, len_ext, lim_ext;
    logic [WAW-1:0] waddr;
    logic [BIW-1:0] bsel;
    logic           cur_bit, wr_en;
    logic [BW-1:0]  start;

    assign n_limit = ({{(BW-LEN_W){1'b0}}, i_managed} > BW'(NUM_BLOCKS)) ?
                     BW'(NUM_BLOCKS) : {{(BW-LEN_W){1'b0}}, i_managed};
    assign n_blk   = BW'(i_address >> BSH);
    assign blk_ext = LW'(r_blk);
    assign len_ext = LW'(r_len);
    assign lim_ext = LW'(r_limit);
    assign waddr   = r_pos[BIW +: WAW];
    assign bsel    = r_pos[BIW-1:0];
    assign cur_bit = r_word[bsel];
    assign start   = r_pos + BW'(1) - BW'(r_len);
    assign wr_en   = (i_cmd.mark_step || i_cmd.clear_step) &&
                     (o_stat.word_last || o_stat.run_end);

    always_comb begin
        n_word       = r_word;
        n_word[bsel] = i_cmd.mark_step;
    end

    always_comb begin
        o_stat.action     = r_act;
        o_stat.req_bad    = 1'b1;
        case (r_act)
            ACT_ALLOC: o_stat.req_bad = (r_len == '0) || (len_ext > lim_ext);
            ACT_FREE:  o_stat.req_bad = (r_len == '0) || (blk_ext + len_ext > lim_ext);
            ACT_TEST:  o_stat.req_bad = (r_blk >= r_limit);
            default:   o_stat.req_bad = 1'b1;
        endcase
        o_stat.scan_end   = (r_pos >= r_limit);
        o_stat.scan_found = !o_stat.scan_end && !cur_bit &&
                            (r_cnt + BW'(1) == BW'(r_len));
        o_stat.run_end    = (r_pos + BW'(1) == r_end);
        o_stat.word_last  = (bsel == BIW'(WORD_BITS - 1));
        o_stat.marking    = r_found;
        o_stat.out_busy   = r_ovalid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= n_word;
        end
        if (i_cmd.fetch) begin
            r_rd    <= mem[waddr];
            r_rd_ok <= r_wok[waddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wok    <= '0;
            r_free   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_act    <= i_action;
                r_blk    <= n_blk;
                r_len    <= i_run_length;
                r_limit  <= n_limit;
                r_pos    <= (i_action == ACT_ALLOC) ? '0 : n_blk;
                r_end    <= n_blk + BW'(i_run_length);
                r_cnt    <= '0;
                r_status <= ST_BAD;
                r_raddr  <= '0;
                r_used   <= 1'b0;
                r_found  <= 1'b0;
            end
            if (i_cmd.latch) begin
                r_word <= r_rd_ok ? r_rd : '1;
            end
            if (wr_en) begin
                r_wok[waddr] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_status <= o_stat.req_bad ? ST_BAD : ST_NOFIT;
            end
            if (i_cmd.scan_step) begin
                if (o_stat.scan_found) begin
                    r_pos    <= start;
                    r_end    <= r_pos + BW'(1);
                    r_status <= ST_OK;
                    r_raddr  <= ADDR_W'(start) << BSH;
                    r_free   <= r_free - CNT_W'(r_len);
                    r_found  <= 1'b1;
                end else if (!o_stat.scan_end) begin
                    r_cnt <= cur_bit ? '0 : r_cnt + BW'(1);
                    r_pos <= r_pos + BW'(1);
                end
            end
            if (i_cmd.mark_step) begin
                r_word <= n_word;
                r_pos  <= r_pos + BW'(1);
            end
            if (i_cmd.clear_step) begin
                r_status <= ST_OK;
                r_word   <= n_word;
                if (cur_bit) begin
                    r_free <= r_free + CNT_W'(1);
                end
                r_pos <= r_pos + BW'(1);
            end
            if (i_cmd.test_step) begin
                r_status <= ST_OK;
                r_used   <= cur_bit;
            end
            if (i_cmd.push) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= r_status;
                r_oraddr  <= r_raddr;
                r_oused   <= r_used;
                r_ofree   <= r_free;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_run_address = r_oraddr;
    assign o_block_used  = r_oused;
    assign o_free_count  = r_ofree;

endmodule
